// ===== rtl/fsr_pkg.sv =====
// Shared constants, codes and a saturation helper of the forward swap rate engine.
`default_nettype none
package fsr_pkg;

  localparam int FRAC_BITS = 24;
  localparam int NUM_MAT   = 64;
  localparam int ADDR_W    = $clog2(NUM_MAT);
  localparam int IDX_W     = 7;
  localparam int MUL_W     = 64 - FRAC_BITS;
  localparam int DEN_W     = MUL_W + 1;
  localparam int NUM_MAG_W = 32 + FRAC_BITS;
  localparam int NUM_W     = NUM_MAG_W + 1;
  localparam int SUM_W     = 42;

  localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] RATE_RST =
    32'(((64'sd1 <<< FRAC_BITS) * 5 + 50) / 100);
  localparam logic [30:0] TENOR_RST = 31'd8388608;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_SWAPR = 3'd1;
  localparam logic [2:0] OP_PRICE = 3'd2;
  localparam logic [2:0] OP_ANNU  = 3'd3;
  localparam logic [2:0] OP_ZERO  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_IDX  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  localparam logic CFG_TENOR  = 1'b0;
  localparam logic CFG_STRIKE = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -SUM_W'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fsr_mul.sv =====
// Registered fixed-point multiplier with truncation toward zero.
`default_nettype none
module fsr_mul import fsr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic signed [31:0]      a_i,
  input  wire logic signed [31:0]      b_i,
  output logic signed [MUL_W-1:0]      p_o
);

  logic signed [63:0] prod;
  logic [63:0]        mag;
  logic [63:0]        shf;
  logic signed [MUL_W-1:0] p_d, p_q;

  always_comb begin
    prod = a_i * b_i;
    mag  = prod[63] ? 64'(-prod) : 64'(prod);
    shf  = mag >> FRAC_BITS;
    p_d  = prod[63] ? MUL_W'(-shf) : MUL_W'(shf);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== rtl/fsr_div.sv =====
// Radix-2 restoring signed divider, truncating, saturated to 32 bits.
`default_nettype none
module fsr_div import fsr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire div_req_t           req_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_MAG_W);

  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-2:0]     dv_q, dv_d;
  logic [NUM_MAG_W-1:0] q_q, q_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d, fin_q, fin_d, neg_q, neg_d;
  logic [DEN_W-1:0]     trial;
  logic signed [NUM_W-1:0] nabs;
  logic signed [DEN_W-1:0] dabs;

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    fin_d  = 1'b0;
    nabs   = req_i.num[NUM_W-1] ? -req_i.num : req_i.num;
    dabs   = req_i.den[DEN_W-1] ? -req_i.den : req_i.den;
    trial  = {rem_q[DEN_W-2:0], q_q[NUM_MAG_W-1]};
    if (req_i.start) begin
      rem_d  = '0;
      q_d    = nabs[NUM_MAG_W-1:0];
      dv_d   = dabs[DEN_W-2:0];
      neg_d  = req_i.num[NUM_W-1] ^ req_i.den[DEN_W-1];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_d = trial - {1'b0, dv_q};
        q_d   = {q_q[NUM_MAG_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d   = {q_q[NUM_MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_MAG_W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    q_q   <= q_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      if (q_q > NUM_MAG_W'(64'd2147483648)) quot_o = 32'sh80000000;
      else quot_o = 32'(-q_q);
    end else begin
      if (q_q > NUM_MAG_W'(64'd2147483647)) quot_o = 32'sh7fffffff;
      else quot_o = q_q[31:0];
    end
  end

  assign done_o = fin_q;

endmodule
`default_nettype wire

// ===== rtl/fsr_tbl.sv =====
// Forward rate table: one write port, registered read, per-entry valid bits.
`default_nettype none
module fsr_tbl import fsr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic signed [31:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic signed [31:0]     rdata_o
);

  logic signed [31:0] mem [NUM_MAT];
  logic [NUM_MAT-1:0] vld_q;
  logic signed [31:0] rd_q;
  logic               rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rv_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rv_q ? rd_q : RATE_RST;

endmodule
`default_nettype wire

// ===== rtl/forward_swap_rate_engine.sv =====
// Top level of the forward swap rate engine: sequencer around shared multiplier and divider.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item: an operation and indices.
//   Output channel (out_valid_o/out_ready_i) returns one item per input item:
//   result_value_o and status_o.
//   Config channel (cfg_valid_i/cfg_ready_o) writes tenor (index 0) or strike
//   (index 1); always ready, write only while idle.
// Sequencing:
//   A rate write or a rejected item goes straight to the result state.
//   A query walks k from o to its last index; each step runs sequencing and
//   multiplier work, every step but the last adds a division in the shared
//   bit-serial divider, and a swap rate adds one more division at the end.
//   One item at a time: in_ready_o is low from acceptance until the result
//   has been taken.
// Reset:
//   Every rate entry reads 0.05, tenor is 0.5 and strike 0; no clearing pass.
// Stall:
//   A result holds on the output until taken; no new item enters meanwhile.
`default_nettype none
module forward_swap_rate_engine import fsr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [5:0]         write_index_i,
  input  wire logic signed [31:0] rate_value_i,
  input  wire logic [6:0]         obs_index_i,
  input  wire logic [6:0]         start_index_i,
  input  wire logic [6:0]         end_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [1:0]              status_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TOP    = 4'd1;
  localparam logic [3:0] S_SUMMUL = 4'd2;
  localparam logic [3:0] S_SUMADD = 4'd3;
  localparam logic [3:0] S_RMUL   = 4'd4;
  localparam logic [3:0] S_DCHK   = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_FINAL1 = 4'd7;
  localparam logic [3:0] S_FINAL2 = 4'd8;
  localparam logic [3:0] S_FDIVW  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] st_q, st_d;
  logic [2:0] op_q, op_d;
  logic [IDX_W-1:0] k_q, k_d, s_q, s_d, m_q, m_d, hi_q, hi_d, lo_q, lo_d;
  logic signed [31:0] b_q, b_d, bs_q, bs_d, bm_q, bm_d, sum_q, sum_d;
  logic signed [31:0] res_q, res_d;
  logic [1:0] stat_q, stat_d;
  logic ov_q, ov_d;
  logic [30:0] tenor_q;
  logic signed [31:0] strike_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [MUL_W-1:0] mul_p;
  div_req_t div_req;
  logic div_done;
  logic signed [31:0] div_quot;
  logic signed [31:0] rd_rate;
  logic tbl_we;
  logic signed [DEN_W-1:0] dval;
  logic [IDX_W-1:0] hi_in, lo_in;
  logic ok_in;

  fsr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  fsr_tbl u_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (write_index_i[ADDR_W-1:0]),
    .wdata_i (rate_value_i),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (rd_rate)
  );

  assign in_ready_o  = (st_q == S_IDLE) && !ov_q;
  assign cfg_ready_o = 1'b1;
  assign tbl_we = in_valid_i && in_ready_o && (operation_i == OP_WRITE) &&
                  ({1'b0, write_index_i} < IDX_W'(NUM_MAT));

  assign hi_in = (operation_i == OP_ZERO) ? start_index_i : end_index_i;
  assign lo_in = (operation_i == OP_ANNU) ? start_index_i : start_index_i + 1'b1;
  assign ok_in = (obs_index_i <= start_index_i) && (start_index_i <= hi_in) &&
                 (hi_in <= IDX_W'(NUM_MAT));
  assign dval  = $signed({mul_p[MUL_W-1], mul_p}) + DEN_W'(ONE_Q);

  always_comb begin
    st_d = st_q; op_d = op_q; k_d = k_q; s_d = s_q; m_d = m_q;
    hi_d = hi_q; lo_d = lo_q; b_d = b_q; bs_d = bs_q; bm_d = bm_q;
    sum_d = sum_q; res_d = res_q; stat_d = stat_q; ov_d = ov_q;
    mul_a = $signed({1'b0, tenor_q});
    mul_b = b_q;
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(b_q) <<< FRAC_BITS;
    div_req.den   = dval;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d = operation_i; k_d = obs_index_i; s_d = start_index_i;
          m_d = end_index_i; hi_d = hi_in; lo_d = lo_in;
          b_d = ONE_Q; bs_d = ONE_Q; bm_d = ONE_Q; sum_d = '0;
          res_d = '0; stat_d = ST_OK;
          if (operation_i == OP_WRITE) begin
            if (!tbl_we) stat_d = ST_IDX;
            st_d = S_FIN;
          end else if (operation_i > OP_ZERO || !ok_in) begin
            stat_d = ST_IDX;
            st_d = S_FIN;
          end else begin
            st_d = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (k_q == s_q) bs_d = b_q;
        if (k_q == m_q) bm_d = b_q;
        if (op_q != OP_ZERO && k_q >= lo_q) st_d = S_SUMMUL;
        else if (k_q < hi_q) st_d = S_RMUL;
        else st_d = S_FINAL1;
      end
      S_SUMMUL: st_d = S_SUMADD;
      S_SUMADD: begin
        sum_d = sat32(SUM_W'(sum_q) + SUM_W'(mul_p));
        st_d = (k_q < hi_q) ? S_RMUL : S_FINAL1;
      end
      S_RMUL: begin
        mul_b = rd_rate;
        st_d = S_DCHK;
      end
      S_DCHK: begin
        if (dval == '0) begin
          stat_d = ST_ZDIV;
          st_d = S_FIN;
        end else begin
          div_req.start = 1'b1;
          st_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          b_d = div_quot;
          k_d = k_q + 1'b1;
          st_d = S_TOP;
        end
      end
      S_FINAL1: begin
        div_req.num = NUM_W'(SUM_W'(bs_q) - SUM_W'(bm_q)) <<< FRAC_BITS;
        div_req.den = DEN_W'(sum_q);
        mul_a = strike_q;
        mul_b = sum_q;
        case (op_q)
          OP_SWAPR: begin
            if (sum_q == '0) begin
              stat_d = ST_ZDIV;
              st_d = S_FIN;
            end else begin
              div_req.start = 1'b1;
              st_d = S_FDIVW;
            end
          end
          OP_PRICE: st_d = S_FINAL2;
          OP_ANNU: begin
            res_d = sum_q;
            st_d = S_FIN;
          end
          default: begin
            res_d = bs_q;
            st_d = S_FIN;
          end
        endcase
      end
      S_FINAL2: begin
        res_d = sat32(SUM_W'(bs_q) - SUM_W'(bm_q) - SUM_W'(mul_p));
        st_d = S_FIN;
      end
      S_FDIVW: begin
        if (div_done) begin
          res_d = div_quot;
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ov_q     <= 1'b0;
      tenor_q  <= TENOR_RST;
      strike_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i[0] == CFG_TENOR) tenor_q <= cfg_data_i[30:0];
        else strike_q <= $signed(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; k_q <= k_d; s_q <= s_d; m_q <= m_d; hi_q <= hi_d; lo_q <= lo_d;
    b_q <= b_d; bs_q <= bs_d; bm_q <= bm_d; sum_q <= sum_d;
    res_q <= res_d; stat_q <= stat_d;
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = (stat_q == ST_OK) ? res_q : '0;
  assign status_o       = stat_q;

endmodule
`default_nettype wire

// ===== sim/tb_forward_swap_rate_engine.sv =====
// Self-checking testbench for the forward swap rate engine with random stimulus and stalls.
`timescale 1ns / 1ps
module tb_forward_swap_rate_engine;
  import fsr_pkg::*;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         widx;
    logic signed [31:0] rate;
    logic [6:0]         obs;
    logic [6:0]         strt;
    logic [6:0]         fin;
  } rate_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } answer_t;

  localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
  localparam int STALL_LIMIT = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         operation_i = OP_WRITE;
  logic [5:0]         write_index_i = '0;
  logic signed [31:0] rate_value_i = '0;
  logic [6:0]         obs_index_i = '0;
  logic [6:0]         start_index_i = '0;
  logic [6:0]         end_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = CFG_TENOR;
  logic [31:0]        cfg_data_i = '0;

  forward_swap_rate_engine dut (.*);

  rate_item_t pending_items[$];
  answer_t    expected_answers[$];
  rate_item_t live_item;
  longint     curve_model[NUM_MAT];
  longint     tenor_model;
  longint     strike_model;
  int         in_gap = 0;
  int         out_gap = 0;
  int         hold_cycles = 0;
  int         holds_asked = 0;
  int         holds_done = 0;
  int         mismatches = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / ONE_L;
  endfunction

  function automatic answer_t price_item(rate_item_t it);
    longint  b, bs, bm, sum, d;
    int      hi, lo, k;
    bit      zdiv;
    answer_t ans;
    ans = '{value: '0, status: ST_OK};
    if (it.op == OP_WRITE) begin
      curve_model[it.widx] = longint'(it.rate);
    end else if (it.op <= OP_ZERO) begin
      hi = (it.op == OP_ZERO) ? int'(it.strt) : int'(it.fin);
      lo = (it.op == OP_ANNU) ? int'(it.strt) : int'(it.strt) + 1;
      if (!(it.obs <= it.strt && it.strt <= hi && hi <= NUM_MAT)) begin
        ans.status = ST_IDX;
      end else begin
        b = ONE_L;
        bs = ONE_L;
        bm = ONE_L;
        sum = 0;
        zdiv = 1'b0;
        k = int'(it.obs);
        while (k <= hi && !zdiv) begin
          if (k == it.strt) bs = b;
          if (k == it.fin) bm = b;
          if (it.op != OP_ZERO && k >= lo) sum = clip32(sum + qmul(tenor_model, b));
          if (k < hi) begin
            d = ONE_L + qmul(tenor_model, curve_model[k]);
            if (d == 0) zdiv = 1'b1;
            else b = clip32((b * ONE_L) / d);
          end
          k++;
        end
        if (zdiv) begin
          ans.status = ST_ZDIV;
        end else if (it.op == OP_SWAPR) begin
          if (sum == 0) ans.status = ST_ZDIV;
          else ans.value = 32'(clip32(((bs - bm) * ONE_L) / sum));
        end else if (it.op == OP_PRICE) begin
          ans.value = 32'(clip32(bs - bm - qmul(strike_model, sum)));
        end else if (it.op == OP_ANNU) begin
          ans.value = 32'(sum);
        end else begin
          ans.value = 32'(bs);
        end
      end
    end else begin
      ans.status = ST_IDX;
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_answers.push_back(price_item(live_item));
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          in_gap <= $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          live_item = pending_items.pop_front();
          operation_i <= live_item.op;
          write_index_i <= live_item.widx;
          rate_value_i <= live_item.rate;
          obs_index_i <= live_item.obs;
          start_index_i <= live_item.strt;
          end_index_i <= live_item.fin;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected item: value %0d status %0d",
                                        result_value_o, status_o);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (want.value !== result_value_o || want.status !== status_o) begin
            errors++;
            if (mismatches < 10) $display("mismatch: expected value %0d status %0d, got %0d %0d",
                                          want.value, want.status, result_value_o, status_o);
            mismatches++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else if (holds_done < holds_asked) begin
        holds_done <= holds_done + 1;
        hold_cycles <= 400;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TENOR) tenor_model = longint'(data[30:0]);
    else strike_model = longint'($signed(data));
  endtask

  task automatic add(input logic [2:0] op, input logic [5:0] widx,
                     input logic signed [31:0] rate,
                     input int obs, input int strt, input int fin);
    pending_items.push_back('{op: op, widx: widx, rate: rate,
                              obs: 7'(obs), strt: 7'(strt), fin: 7'(fin)});
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_answers.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_random(input int count);
    int o, s, m, pick;
    logic signed [31:0] r;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: r = $urandom;
        1: r = 32'sd838861 + $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
        2: r = $signed(32'($urandom_range(0, 33554431))) - 32'sd16777216;
        default: r = $signed(32'($urandom_range(0, 4194303)));
      endcase
      if ($urandom_range(0, 24) == 0) begin
        o = 0;
        s = $urandom_range(0, 8);
        m = 64;
      end else if ($urandom_range(0, 9) == 0) begin
        o = $urandom_range(0, 127);
        s = $urandom_range(0, 127);
        m = $urandom_range(0, 127);
      end else begin
        o = $urandom_range(0, 64);
        s = o + $urandom_range(0, 3);
        m = s + $urandom_range(0, 5);
        if (s > 64) s = 64;
        if (m > 64) m = 64;
      end
      if (pick < 30) add(OP_WRITE, 6'($urandom_range(0, 63)), r, o, s, m);
      else if (pick < 95) add(3'($urandom_range(OP_SWAPR, OP_ZERO)), 6'($urandom), r, o, s, m);
      else add(3'($urandom_range(5, 7)), 6'($urandom), r, o, s, m);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_MAT; i++) curve_model[i] = longint'(RATE_RST);
    tenor_model = longint'(TENOR_RST);
    strike_model = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_TENOR, 32'd8388608);
    write_reg(CFG_STRIKE, 32'd0);
    add(OP_ZERO, 0, 0, 5, 5, 0);
    add(OP_SWAPR, 0, 0, 0, 0, 64);
    add(OP_PRICE, 0, 0, 0, 1, 64);
    add(OP_ANNU, 0, 0, 0, 0, 64);
    add(OP_ZERO, 0, 0, 0, 64, 0);
    add(OP_SWAPR, 0, 0, 3, 7, 7);
    add(OP_PRICE, 0, 0, 3, 7, 7);
    add(OP_SWAPR, 0, 0, 64, 64, 64);
    add(OP_ANNU, 0, 0, 64, 64, 64);
    add(OP_SWAPR, 0, 0, 5, 4, 9);
    add(OP_PRICE, 0, 0, 2, 6, 5);
    add(OP_ANNU, 0, 0, 0, 0, 65);
    add(OP_ZERO, 0, 0, 3, 65, 127);
    add(OP_ZERO, 0, 0, 127, 127, 127);
    add(3'd5, 63, 32'sh7fffffff, 0, 0, 0);
    add(3'd7, 0, 0, 1, 2, 3);
    add(OP_WRITE, 63, 32'sh7fffffff, 0, 0, 0);
    add(OP_WRITE, 0, 32'sh80000000, 0, 0, 0);
    add(OP_WRITE, 3, -32'sd33554432, 0, 0, 0);
    add(OP_SWAPR, 0, 0, 0, 2, 10);
    add(OP_ZERO, 0, 0, 2, 4, 0);
    add(OP_WRITE, 3, 32'sd0, 0, 0, 0);
    add(OP_ANNU, 0, 0, 0, 0, 64);
    add(OP_ZERO, 0, 0, 60, 64, 0);
    add_random(40);
    drain();

    write_reg(CFG_TENOR, 32'd0);
    write_reg(CFG_STRIKE, 32'h7fffffff);
    add_random(20);
    holds_asked = 1;
    add_random(30);
    drain();

    write_reg(CFG_TENOR, 32'h7fffffff);
    write_reg(CFG_STRIKE, 32'h80000000);
    add_random(50);
    drain();

    write_reg(CFG_TENOR, $urandom);
    write_reg(CFG_STRIKE, $urandom);
    add_random(50);
    drain();

    write_reg(CFG_TENOR, 32'h80000000 | 32'd16777216);
    write_reg(CFG_STRIKE, 32'($signed(32'($urandom_range(0, 33554431))) - 32'sd16777216));
    calm = 1'b1;
    add_random(55);
    drain();

    repeat (20) @(posedge clk_i);
    errors += expected_answers.size();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
